>>> src/seconds_to_calendar_date_core_defines.svh
// ----------------------------------------------------------------------------
// Seconds to calendar date core: assertion macros
// Shared concurrent check forms for the converter RTL.
// ----------------------------------------------------------------------------
`ifndef SECONDS_TO_CALENDAR_DATE_CORE_DEFINES_SVH
`define SECONDS_TO_CALENDAR_DATE_CORE_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define STCD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stcd: same-cycle check failed");

// Next-cycle implication, quiet during reset.
`define STCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stcd: next-cycle check failed");

`endif

>>> src/stcd_pkg.sv
// ----------------------------------------------------------------------------
// stcd_pkg
// Types and constants shared by the seconds to calendar date converter.
// ----------------------------------------------------------------------------
`default_nettype none

package stcd_pkg;

   localparam int DIVIDEND_W = 32;
   localparam int DIVISOR_W  = 17;
   localparam int COUNT_W    = 6;
   localparam int DAYS_W     = 16;

   localparam logic [31:0] EPOCH_2000_SECONDS = 32'd946684800;
   localparam logic [31:0] END_2100_SECONDS   = 32'd4102444800;

   localparam logic [DIVISOR_W-1:0] SECONDS_PER_DAY = 17'd86400;
   localparam logic [DIVISOR_W-1:0] SIXTY           = 17'd60;
   localparam logic [DIVISOR_W-1:0] DAYS_PER_WEEK   = 17'd7;

   localparam logic [DAYS_W-1:0] WEEKDAY_OF_2000 = 16'd6;
   localparam logic [DAYS_W-1:0] DAYS_PER_QUAD   = 16'd1461;
   localparam logic [DAYS_W-1:0] DAYS_LEAP_YEAR  = 16'd366;
   localparam logic [DAYS_W-1:0] DAYS_YEAR       = 16'd365;

   localparam logic [6:0] LAST_YEAR  = 7'd99;
   localparam logic [3:0] LAST_MONTH = 4'd11;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
      logic [COUNT_W-1:0]    nbits;
   } div_req_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
      logic [DIVISOR_W-1:0]  remainder;
   } div_res_type;

   typedef struct packed {
      logic       busy;
      logic [4:0] day;
      logic [3:0] month;
      logic [6:0] year;
   } date_res_type;

   // Days in a month, month index 0 is January.
   function automatic logic [DAYS_W-1:0] month_len(input logic [3:0] mon, input logic leap);
      logic [DAYS_W-1:0] len;
      unique case (mon)
         4'd1:                      len = leap ? 16'd29 : 16'd28;
         4'd3, 4'd5, 4'd8, 4'd10:   len = 16'd30;
         default:                   len = 16'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

>>> src/stcd_serdiv.sv
// ----------------------------------------------------------------------------
// stcd_serdiv
// Restoring divider, one quotient bit per cycle, dividend left aligned.
// ----------------------------------------------------------------------------
`default_nettype none

module stcd_serdiv (
   input  wire                       clock,
   input  wire                       reset,
   input  wire stcd_pkg::div_req_type req,
   output stcd_pkg::div_res_type     res
);
   import stcd_pkg::*;

   logic [DIVIDEND_W-1:0] num_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  dvs_ff;
   logic [COUNT_W-1:0]    cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;

   logic [DIVISOR_W:0]    partial;
   logic [DIVISOR_W:0]    diff;
   logic                  qbit;

   assign partial = {rem_ff, num_ff[DIVIDEND_W-1]};
   assign diff    = partial - {1'b0, dvs_ff};
   assign qbit    = ~diff[DIVISOR_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            num_ff  <= req.dividend;
            dvs_ff  <= req.divisor;
            cnt_ff  <= req.nbits;
            quo_ff  <= '0;
            rem_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            num_ff <= {num_ff[DIVIDEND_W-2:0], 1'b0};
            quo_ff <= {quo_ff[DIVIDEND_W-2:0], qbit};
            rem_ff <= qbit ? diff[DIVISOR_W-1:0] : partial[DIVISOR_W-1:0];
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == COUNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign res.busy      = busy_ff;
   assign res.done      = done_ff;
   assign res.quotient  = quo_ff;
   assign res.remainder = rem_ff;

endmodule

`default_nettype wire

>>> src/stcd_date.sv
// ----------------------------------------------------------------------------
// stcd_date
// Iterative year and month search over a day count since 2000-01-01.
// ----------------------------------------------------------------------------
`default_nettype none

module stcd_date (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   input  wire [stcd_pkg::DAYS_W-1:0] days,
   output stcd_pkg::date_res_type     res
);
   import stcd_pkg::*;

   typedef enum logic [1:0] {D_IDLE, D_QUAD, D_YEAR, D_MONTH} phase_type;

   phase_type         phase_ff;
   logic [DAYS_W-1:0] days_ff;
   logic [6:0]        year_ff;
   logic [3:0]        mon_ff;
   logic              leap_ff;

   logic [DAYS_W-1:0] year_len;
   logic [DAYS_W-1:0] mon_len;

   assign year_len = (year_ff[1:0] == 2'd0) ? DAYS_LEAP_YEAR : DAYS_YEAR;
   assign mon_len  = month_len(mon_ff, leap_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= D_IDLE;
      end else begin
         unique case (phase_ff)
            D_IDLE: begin
               if (start) begin
                  days_ff  <= days;
                  year_ff  <= '0;
                  mon_ff   <= '0;
                  phase_ff <= D_QUAD;
               end
            end
            D_QUAD: begin
               // Strip whole four-year groups first.
               if (days_ff >= DAYS_PER_QUAD) begin
                  days_ff <= days_ff - DAYS_PER_QUAD;
                  year_ff <= year_ff + 7'd4;
               end else begin
                  phase_ff <= D_YEAR;
               end
            end
            D_YEAR: begin
               if (days_ff >= year_len && year_ff < LAST_YEAR) begin
                  days_ff <= days_ff - year_len;
                  year_ff <= year_ff + 7'd1;
               end else begin
                  leap_ff  <= (year_ff[1:0] == 2'd0);
                  phase_ff <= D_MONTH;
               end
            end
            D_MONTH: begin
               if (days_ff >= mon_len && mon_ff < LAST_MONTH) begin
                  days_ff <= days_ff - mon_len;
                  mon_ff  <= mon_ff + 4'd1;
               end else begin
                  phase_ff <= D_IDLE;
               end
            end
            default: phase_ff <= D_IDLE;
         endcase
      end
   end

   assign res.busy  = (phase_ff != D_IDLE);
   assign res.day   = days_ff[4:0] + 5'd1;
   assign res.month = mon_ff + 4'd1;
   assign res.year  = year_ff;

endmodule

`default_nettype wire

>>> src/seconds_to_calendar_date_core.sv
// Sequence: an in-range item makes four passes through the shared serial divider, of
//   32, 17, 11 and 16 quotient bits, each with a load and a handoff, then a join that
//   waits for the year/month search and a deliver step; out of range goes to delivery.
// Flow: one item at a time; the next item is taken the cycle after the result
//   enters the output register, and delivery waits while the output register stays full.
//   The year/month search runs beside the divider.
// ----------------------------------------------------------------------------
// seconds_to_calendar_date_core
// Converts a 32-bit Unix time into calendar fields for the years 2000..2099.
// Reset: synchronous, active high; clears the sequencer, the launch pulses and
// the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

`include "seconds_to_calendar_date_core_defines.svh"

module seconds_to_calendar_date_core (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire [31:0] req_unix_seconds,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [5:0] rsp_second,
   output logic [5:0] rsp_minute,
   output logic [4:0] rsp_hour,
   output logic [3:0] rsp_hour_twelve,
   output logic       rsp_is_pm,
   output logic [4:0] rsp_day,
   output logic [3:0] rsp_month,
   output logic [6:0] rsp_year_offset,
   output logic [2:0] rsp_weekday,
   output logic       rsp_out_of_range
);
   import stcd_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DIV_DAY, S_DIV_SEC, S_DIV_MIN, S_DIV_WEEK, S_JOIN, S_DELIVER
   } state_type;

   state_type         state_ff;
   div_req_type       div_req_ff;
   div_res_type       div_res;
   date_res_type      date_res;
   logic              date_start_ff;
   logic [DAYS_W-1:0] days_ff;
   logic [5:0]        second_ff;
   logic [5:0]        minute_ff;
   logic [4:0]        hour_ff;
   logic [2:0]        weekday_ff;
   logic              oor_ff;
   logic              rsp_valid_ff;

   logic              req_xfer;
   logic              in_range;
   logic [31:0]       secs_in;
   logic [DAYS_W-1:0] week_in;
   logic [3:0]        twelve_in;
   logic              pm_in;

   // Shared bit-serial divider: day split, seconds, minutes, weekday.
   stcd_serdiv u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req_ff),
      .res   (div_res)
   );

   // Year and month search, started as soon as the day count is known.
   stcd_date u_date (
      .clock (clock),
      .reset (reset),
      .start (date_start_ff),
      .days  (days_ff),
      .res   (date_res)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign in_range  = (req_unix_seconds >= EPOCH_2000_SECONDS) &&
                      (req_unix_seconds <  END_2100_SECONDS);
   assign secs_in   = req_unix_seconds - EPOCH_2000_SECONDS;
   assign week_in   = days_ff + WEEKDAY_OF_2000;

   // Midnight reads 12 AM, noon reads 12 PM.
   always_comb begin
      pm_in = (hour_ff >= 5'd12);
      priority if (hour_ff == 5'd0) begin
         twelve_in = 4'd12;
      end else if (hour_ff > 5'd12) begin
         twelve_in = 4'(hour_ff - 5'd12);
      end else begin
         twelve_in = hour_ff[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_valid_ff     <= 1'b0;
         div_req_ff.start <= 1'b0;
         date_start_ff    <= 1'b0;
      end else begin
         // Launch pulses last one cycle.
         div_req_ff.start <= 1'b0;
         date_start_ff    <= 1'b0;
         // Drop the result once the consumer takes the transfer.
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  oor_ff <= ~in_range;
                  if (in_range) begin
                     div_req_ff <= '{start: 1'b1, dividend: secs_in,
                                     divisor: SECONDS_PER_DAY, nbits: COUNT_W'(32)};
                     state_ff   <= S_DIV_DAY;
                  end else begin
                     state_ff <= S_DELIVER;
                  end
               end
            end
            S_DIV_DAY: begin
               if (div_res.done) begin
                  days_ff       <= div_res.quotient[DAYS_W-1:0];
                  date_start_ff <= 1'b1;
                  // Seconds of the day: 17 significant bits, left aligned.
                  div_req_ff <= '{start: 1'b1,
                                  dividend: {div_res.remainder, 15'b0},
                                  divisor: SIXTY, nbits: COUNT_W'(17)};
                  state_ff   <= S_DIV_SEC;
               end
            end
            S_DIV_SEC: begin
               if (div_res.done) begin
                  second_ff  <= div_res.remainder[5:0];
                  // Minutes of the day stay below 1440: 11 bits.
                  div_req_ff <= '{start: 1'b1,
                                  dividend: {div_res.quotient[10:0], 21'b0},
                                  divisor: SIXTY, nbits: COUNT_W'(11)};
                  state_ff   <= S_DIV_MIN;
               end
            end
            S_DIV_MIN: begin
               if (div_res.done) begin
                  minute_ff  <= div_res.remainder[5:0];
                  hour_ff    <= div_res.quotient[4:0];
                  div_req_ff <= '{start: 1'b1, dividend: {week_in, 16'b0},
                                  divisor: DAYS_PER_WEEK, nbits: COUNT_W'(DAYS_W)};
                  state_ff   <= S_DIV_WEEK;
               end
            end
            S_DIV_WEEK: begin
               if (div_res.done) begin
                  weekday_ff <= div_res.remainder[2:0];
                  state_ff   <= S_JOIN;
               end
            end
            S_JOIN: begin
               if (!date_res.busy) begin
                  state_ff <= S_DELIVER;
               end
            end
            S_DELIVER: begin
               // Hold until the output register is free.
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_out_of_range <= oor_ff;
                  if (oor_ff) begin
                     rsp_second      <= '0;
                     rsp_minute      <= '0;
                     rsp_hour        <= '0;
                     rsp_hour_twelve <= '0;
                     rsp_is_pm       <= 1'b0;
                     rsp_day         <= '0;
                     rsp_month       <= '0;
                     rsp_year_offset <= '0;
                     rsp_weekday     <= '0;
                  end else begin
                     rsp_second      <= second_ff;
                     rsp_minute      <= minute_ff;
                     rsp_hour        <= hour_ff;
                     rsp_hour_twelve <= twelve_in;
                     rsp_is_pm       <= pm_in;
                     rsp_day         <= date_res.day;
                     rsp_month       <= date_res.month;
                     rsp_year_offset <= date_res.year;
                     rsp_weekday     <= weekday_ff;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `STCD_ASSERT_IMPL(a_deliver_date_idle, clock, reset,
      (state_ff == S_DELIVER && !oor_ff), !date_res.busy)
   `STCD_ASSERT_IMPL(a_oor_fields_zero, clock, reset,
      (rsp_valid_ff && rsp_out_of_range), (rsp_month == 4'd0 && rsp_day == 5'd0))
   `STCD_ASSERT_IMPL(a_pm_matches_hour, clock, reset,
      (rsp_valid_ff && !rsp_out_of_range), (rsp_is_pm == (rsp_hour >= 5'd12)))
   `STCD_ASSERT_NEXT(a_launch_when_free, clock, reset,
      (req_xfer && in_range), (div_req_ff.start && !div_res.busy))

endmodule

`default_nettype wire
